// ===== src/bdq_pkg.sv =====
// Package for the bounded deque with search and delete.
// Holds the item structs, opcode and status codes and the controller state type.
// No dependencies.
`default_nettype none

package bdq_pkg;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_SEARCH     = 3'd4;
    localparam logic [2:0] OP_SEARCH_DEL = 3'd5;
    localparam logic [2:0] OP_CLEAR      = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] operand_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [31:0] removed_value;
        logic [4:0]         count_after;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== src/bounded_deque_with_search_delete.sv =====
// Bounded deque with search and delete: circular entry memory plus controller.
// Depends on bdq_pkg for item structs, codes and the state type.
//
//   channel  valid        stall        payload
//   input    i_in_valid   o_in_stall   i_in_item  (bdq_pkg::t_in_item)
//   output   o_out_valid  i_out_stall  o_out_item (bdq_pkg::t_out_item)
//
// Push, clear, unused opcodes and pops on an empty list go straight to the done state; other pops pass through S_POP.
// Search walks the list in S_SCAN: the memory read port walks one entry a cycle.
// Search delete of any entry but the last adds S_SHIFT, which moves each later entry down to close the gap.
// Reset clears head, count and the controller; entries are undefined until written.
// A new item is taken while an earlier result waits in the output register.
`default_nettype none

module bounded_deque_with_search_delete #(
    parameter int DEPTH = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire bdq_pkg::t_in_item i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output bdq_pkg::t_out_item   o_out_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_W = (CW+1)'(DEPTH);

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] k);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(k);
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    bdq_pkg::t_state    r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_k, n_k;
    logic [CW-1:0]      r_pos, n_pos;
    logic [CW-1:0]      r_wk, n_wk;
    logic               r_pend, n_pend;
    logic [2:0]         r_op, n_op;
    logic [31:0]        r_val, n_val;
    bdq_pkg::t_out_item r_res, n_res;
    bdq_pkg::t_out_item r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;

    logic               in_acc;
    logic               out_free;
    logic               hit;
    logic               scan_more;
    logic               shift_more;
    logic               full;
    logic               empty;
    logic [CW+4:0]      count_ext;

    assign o_in_stall = r_state != bdq_pkg::S_IDLE;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign hit        = r_pend && (r_rdata == r_val);
    assign scan_more  = r_k < r_count;
    assign shift_more = r_k < r_count;
    assign full       = r_count >= DEPTH_C;
    assign empty      = r_count == '0;
    assign count_ext  = {5'd0, r_count};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bdq_pkg::S_IDLE: begin
                if (in_acc) begin
                    if ((i_in_item.opcode == bdq_pkg::OP_POP_FRONT ||
                         i_in_item.opcode == bdq_pkg::OP_POP_BACK) && !empty) begin
                        n_state = bdq_pkg::S_POP;
                    end else if (i_in_item.opcode == bdq_pkg::OP_SEARCH ||
                                 i_in_item.opcode == bdq_pkg::OP_SEARCH_DEL) begin
                        n_state = bdq_pkg::S_SCAN;
                    end else begin
                        n_state = bdq_pkg::S_DONE;
                    end
                end
            end
            bdq_pkg::S_POP: n_state = bdq_pkg::S_DONE;
            bdq_pkg::S_SCAN: begin
                if (hit) begin
                    if (r_op == bdq_pkg::OP_SEARCH_DEL && (r_pos + 1'b1) < r_count) begin
                        n_state = bdq_pkg::S_SHIFT;
                    end else begin
                        n_state = bdq_pkg::S_DONE;
                    end
                end else if (!scan_more) begin
                    n_state = bdq_pkg::S_DONE;
                end
            end
            bdq_pkg::S_SHIFT: begin
                if (!shift_more) begin
                    n_state = bdq_pkg::S_DONE;
                end
            end
            bdq_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = bdq_pkg::S_IDLE;
                end
            end
            default: n_state = bdq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_k         = r_k;
        n_pos       = r_pos;
        n_wk        = r_wk;
        n_pend      = r_pend;
        n_op        = r_op;
        n_val       = r_val;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        rd_en       = 1'b0;
        rd_addr     = r_head;
        wr_en       = 1'b0;
        wr_addr     = r_head;
        wr_data     = r_val;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            bdq_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_op   = i_in_item.opcode;
                    n_val  = i_in_item.operand_value;
                    n_k    = '0;
                    n_pend = 1'b0;
                    n_res  = '{status: bdq_pkg::ST_OK, found: 1'b0,
                               removed_value: '0, count_after: '0};
                    case (i_in_item.opcode)
                        bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
                            if (full) begin
                                n_res.status = bdq_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_data = i_in_item.operand_value;
                                n_count = r_count + 1'b1;
                                if (i_in_item.opcode == bdq_pkg::OP_PUSH_FRONT) begin
                                    n_head  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
                                    wr_addr = n_head;
                                end else begin
                                    wr_addr = slot(r_head, r_count);
                                end
                            end
                        end
                        bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
                            if (empty) begin
                                n_res.status = bdq_pkg::ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                n_count = r_count - 1'b1;
                                if (i_in_item.opcode == bdq_pkg::OP_POP_FRONT) begin
                                    rd_addr = r_head;
                                    n_head  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
                                end else begin
                                    rd_addr = slot(r_head, r_count - 1'b1);
                                end
                            end
                        end
                        bdq_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_head  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            bdq_pkg::S_POP: begin
                n_res.removed_value = r_rdata;
            end
            bdq_pkg::S_SCAN: begin
                if (hit) begin
                    n_res.found = 1'b1;
                    n_pend      = 1'b0;
                    if (r_op == bdq_pkg::OP_SEARCH_DEL) begin
                        n_res.removed_value = r_rdata;
                        n_k = r_pos + 1'b1;
                        if (!((r_pos + 1'b1) < r_count)) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end else if (scan_more) begin
                    rd_en   = 1'b1;
                    rd_addr = slot(r_head, r_k);
                    n_pos   = r_k;
                    n_k     = r_k + 1'b1;
                    n_pend  = 1'b1;
                end else begin
                    n_res.status = bdq_pkg::ST_EMPTY;
                    n_pend       = 1'b0;
                end
            end
            bdq_pkg::S_SHIFT: begin
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = slot(r_head, r_wk);
                    wr_data = r_rdata;
                end
                if (shift_more) begin
                    rd_en   = 1'b1;
                    rd_addr = slot(r_head, r_k);
                    n_wk    = r_k - 1'b1;
                    n_k     = r_k + 1'b1;
                    n_pend  = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_count = r_count - 1'b1;
                end
            end
            bdq_pkg::S_DONE: begin
                if (out_free) begin
                    n_out             = r_res;
                    n_out.count_after = count_ext[4:0];
                    n_out_valid       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdq_pkg::S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_pos <= n_pos;
        r_wk  <= n_wk;
        r_op  <= n_op;
        r_val <= n_val;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= AW'(DEPTH - 1))
        else $error("head index outside the store");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("item taken while the previous one is in flight");

    a_full_push_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && full && (i_in_item.opcode == bdq_pkg::OP_PUSH_FRONT ||
                           i_in_item.opcode == bdq_pkg::OP_PUSH_BACK)
        |=> $stable(r_count) && $stable(r_head))
        else $error("refused push changed the list");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == bdq_pkg::S_DONE))
        else $error("result issued outside the done state");

endmodule

`default_nettype wire
